FILE: rtl/cwrop_pkg.sv
package cwrop_pkg;

  // Fixed-point formats
  localparam int COEF_FRAC_BITS = 32;
  localparam int STATE_W        = 48;
  localparam int COEF_W         = 64;
  localparam int CLAMP_W        = 63;
  localparam int ACC_W          = 128;
  localparam int CHUNK_W        = 32;
  localparam int MUL_W          = CHUNK_W + 1;
  localparam int PROD_W         = 2 * MUL_W;

  localparam int N_STATE = 6;
  localparam int ROW_W   = $clog2(N_STATE);
  localparam int N_COEF  = 7;

  // Configuration register widths
  localparam int COS_W      = 34;
  localparam int SIN_W      = 34;
  localparam int NM_W       = 33;
  localparam int INV_W      = 49;
  localparam int NDT_W      = 36;
  localparam int CFG_DATA_W = 49;
  localparam int CFG_IDX_W  = 3;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;
  localparam logic signed [COEF_W-1:0] COEF_THREE = COEF_ONE + (COEF_ONE <<< 1);
  localparam logic [COS_W-1:0] COS_RST = COS_W'(1) << COEF_FRAC_BITS;

  // Accumulator rounding and saturation
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam int HI_K = COEF_FRAC_BITS + CLAMP_W - 1;
  localparam int HI_R = COEF_FRAC_BITS + STATE_W - 1;
  localparam logic signed [COEF_W-1:0] K_MAX = (COEF_W'(1) << (CLAMP_W - 1)) - COEF_W'(1);
  localparam logic signed [COEF_W-1:0] K_MIN = ~K_MAX;
  localparam logic signed [STATE_W-1:0] S_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0] S_MIN = ~S_MAX;

  // Microprogram geometry
  localparam int UC_LEN  = 40;
  localparam int UC_ROWS = 16;
  localparam int STEP_W  = $clog2(UC_LEN);
  localparam int PH_W    = 2;
  localparam logic [PH_W-1:0] PH_MAC_LAST = PH_W'(3);
  localparam logic [PH_W-1:0] PH_END_LAST = PH_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS, CFG_SIN, CFG_NM, CFG_INV, CFG_NDT
  } cfg_idx_e;

  typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_e;

  typedef enum logic [2:0] {
    UOP_BR,     // jump to tgt when coefficients are current
    UOP_MAC,    // four partial products into the accumulator
    UOP_CEND,   // drain, round, clamp, write a coefficient
    UOP_REND,   // drain, round, saturate, write a new state element
    UOP_CDONE,  // mark coefficients current
    UOP_DONE    // commit state and result
  } uop_e;

  typedef enum logic [4:0] {
    A_INV, A_N1, A_N3, A_N6, A_F00, A_F10, A_ONE, A_C, A_F34, A_F43, A_F44,
    A_K03, A_K04, A_K13, A_K14, A_K30, A_K40, A_K52
  } a_sel_e;

  typedef enum logic [3:0] {
    B_S, B_M2CM1, B_P2CM1, B_S4N3, B_CM1,
    B_X0, B_X1, B_X2, B_X3, B_X4, B_X5
  } b_sel_e;

  typedef enum logic [2:0] {
    KI_03, KI_04, KI_13, KI_14, KI_30, KI_40, KI_52
  } kidx_e;

  typedef struct packed {
    uop_e              op;
    a_sel_e            a_sel;
    b_sel_e            b_sel;
    kidx_e             kdst;
    logic [ROW_W-1:0]  row;
    logic              neg;
    logic [STEP_W-1:0] tgt;
  } uword_t;

  typedef struct packed {
    logic             mac_en;
    logic [PH_W-1:0]  pp;
    a_sel_e           a_sel;
    b_sel_e           b_sel;
    logic             cend;
    logic             rend;
    kidx_e            kdst;
    logic [ROW_W-1:0] row;
    logic             neg;
    logic             commit;
  } ctrl_t;

  function automatic uword_t uw(uop_e op, a_sel_e a, b_sel_e b, kidx_e k, int row,
                                logic neg, int tgt);
    uword_t w;
    w.op    = op;
    w.a_sel = a;
    w.b_sel = b;
    w.kdst  = k;
    w.row   = ROW_W'(row);
    w.neg   = neg;
    w.tgt   = STEP_W'(tgt);
    return w;
  endfunction

  function automatic uword_t uw_mac(a_sel_e a, b_sel_e b);
    return uw(UOP_MAC, a, b, KI_03, 0, 1'b0, 0);
  endfunction

  function automatic uword_t uw_cend(kidx_e k, logic neg);
    return uw(UOP_CEND, A_ONE, B_S, k, 0, neg, 0);
  endfunction

  function automatic uword_t uw_rend(int row);
    return uw(UOP_REND, A_ONE, B_S, KI_03, row, 1'b0, 0);
  endfunction

  function automatic uword_t uw_op(uop_e op, int tgt);
    return uw(op, A_ONE, B_S, KI_03, 0, 1'b0, tgt);
  endfunction

  // Step program: coefficient products (skipped when current), then F * state.
  function automatic uword_t ucode(logic [STEP_W-1:0] step);
    uword_t w;
    w = uw_op(UOP_DONE, 0);
    case (int'(step))
      0:  w = uw_op(UOP_BR, UC_ROWS);
      1:  w = uw_mac(A_INV, B_S);
      2:  w = uw_cend(KI_03, 1'b0);
      3:  w = uw_mac(A_INV, B_M2CM1);
      4:  w = uw_cend(KI_04, 1'b0);
      5:  w = uw_mac(A_INV, B_P2CM1);
      6:  w = uw_cend(KI_13, 1'b0);
      7:  w = uw_mac(A_INV, B_S4N3);
      8:  w = uw_cend(KI_14, 1'b0);
      9:  w = uw_mac(A_N3, B_S);
      10: w = uw_cend(KI_30, 1'b0);
      11: w = uw_mac(A_N6, B_CM1);
      12: w = uw_cend(KI_40, 1'b0);
      13: w = uw_mac(A_N1, B_S);
      14: w = uw_cend(KI_52, 1'b1);
      15: w = uw_op(UOP_CDONE, 0);
      16: w = uw_mac(A_F00, B_X0);
      17: w = uw_mac(A_K03, B_X3);
      18: w = uw_mac(A_K04, B_X4);
      19: w = uw_rend(0);
      20: w = uw_mac(A_F10, B_X0);
      21: w = uw_mac(A_ONE, B_X1);
      22: w = uw_mac(A_K13, B_X3);
      23: w = uw_mac(A_K14, B_X4);
      24: w = uw_rend(1);
      25: w = uw_mac(A_C, B_X2);
      26: w = uw_mac(A_K03, B_X5);
      27: w = uw_rend(2);
      28: w = uw_mac(A_K30, B_X0);
      29: w = uw_mac(A_C, B_X3);
      30: w = uw_mac(A_F34, B_X4);
      31: w = uw_rend(3);
      32: w = uw_mac(A_K40, B_X0);
      33: w = uw_mac(A_F43, B_X3);
      34: w = uw_mac(A_F44, B_X4);
      35: w = uw_rend(4);
      36: w = uw_mac(A_K52, B_X2);
      37: w = uw_mac(A_C, B_X5);
      38: w = uw_rend(5);
      default: w = uw_op(UOP_DONE, 0);
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/cw_relative_orbit_propagator_unit.sv
// Clohessy-Wiltshire relative orbit propagator. Holds (x, y, z, vx, vy, vz) in
// signed Q32.16. A request with op_i = 0 loads the state from the load fields
// and returns nothing. A request with op_i = 1 replaces the state by
// F * state (F the CW transition matrix built from cos_ndt, sin_ndt, mean_motion,
// inv_mean_motion and n_dt, all Q.32) and returns the new position plus an
// overflow flag set when any of the six new elements saturated. Every product
// goes through one 33x33 signed multiplier in four partial-product passes under
// a microcode sequencer. The first step after any configuration write runs longer
// because the seven product coefficients of F are recomputed then and kept
// afterwards. Input is taken only while the sequencer is idle; a result waiting
// on the output does not block loads, and a step finishes once the output is free.
// Configuration writes (cfg_we_i, cfg_idx_i 0..4, others ignored) must be issued
// only while no step is in flight.
module cw_relative_orbit_propagator_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   op_i,
  input  logic signed [cwrop_pkg::STATE_W-1:0]   load_x_i,
  input  logic signed [cwrop_pkg::STATE_W-1:0]   load_y_i,
  input  logic signed [cwrop_pkg::STATE_W-1:0]   load_z_i,
  input  logic signed [cwrop_pkg::STATE_W-1:0]   load_vx_i,
  input  logic signed [cwrop_pkg::STATE_W-1:0]   load_vy_i,
  input  logic signed [cwrop_pkg::STATE_W-1:0]   load_vz_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [cwrop_pkg::STATE_W-1:0]   pos_x_o,
  output logic signed [cwrop_pkg::STATE_W-1:0]   pos_y_o,
  output logic signed [cwrop_pkg::STATE_W-1:0]   pos_z_o,
  output logic                                   overflow_o,
  input  logic                                   cfg_we_i,
  input  logic [cwrop_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [cwrop_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  // Configuration registers
  logic [cwrop_pkg::COS_W-1:0] cos_q;
  logic [cwrop_pkg::SIN_W-1:0] sin_q;
  logic [cwrop_pkg::NM_W-1:0]  nm_q;
  logic [cwrop_pkg::INV_W-1:0] inv_q;
  logic [cwrop_pkg::NDT_W-1:0] ndt_q;

  // Config values widened to the 64-bit operand format
  logic signed [cwrop_pkg::COEF_W-1:0] c64, s64, n64, inv64, ndt64;

  // Derived operands, refreshed every cycle (the user keeps config static during a step; the block does not enforce it)
  logic signed [cwrop_pkg::COEF_W-1:0] f00_q, f10_q, f43_q, f44_q, n3_q, n6_q;
  logic signed [cwrop_pkg::COEF_W-1:0] cm1_q, m2cm1_q, p2cm1_q, s4n3_q;
  logic signed [cwrop_pkg::COEF_W-1:0] sd;

  // Product coefficients of F, written by the microprogram
  logic signed [cwrop_pkg::COEF_W-1:0]  k_q [cwrop_pkg::N_COEF];

  logic signed [cwrop_pkg::STATE_W-1:0] state_q [cwrop_pkg::N_STATE];
  logic signed [cwrop_pkg::STATE_W-1:0] nxt_q   [cwrop_pkg::N_STATE];
  logic signed [cwrop_pkg::STATE_W-1:0] b_state;

  logic signed [cwrop_pkg::COEF_W-1:0]  a_op, b_op;
  logic signed [cwrop_pkg::COEF_W-1:0]  coef_res;
  logic signed [cwrop_pkg::STATE_W-1:0] row_res;
  logic                                 row_ov;

  logic                                 out_valid_q;
  logic                                 ov_acc_q;
  logic                                 ov_q;
  logic signed [cwrop_pkg::STATE_W-1:0] pos_x_q, pos_y_q, pos_z_q;

  logic             busy;
  logic             in_acc;
  logic             out_free;
  cwrop_pkg::ctrl_t ctrl;

  assign in_ready_o = ~busy;
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= cwrop_pkg::COS_RST;
      sin_q <= '0;
      nm_q  <= '0;
      inv_q <= '0;
      ndt_q <= '0;
    end else if (cfg_we_i) begin
      case (cwrop_pkg::cfg_idx_e'(cfg_idx_i))
        cwrop_pkg::CFG_COS: cos_q <= cfg_wdata_i[cwrop_pkg::COS_W-1:0];
        cwrop_pkg::CFG_SIN: sin_q <= cfg_wdata_i[cwrop_pkg::SIN_W-1:0];
        cwrop_pkg::CFG_NM:  nm_q  <= cfg_wdata_i[cwrop_pkg::NM_W-1:0];
        cwrop_pkg::CFG_INV: inv_q <= cfg_wdata_i[cwrop_pkg::INV_W-1:0];
        cwrop_pkg::CFG_NDT: ndt_q <= cfg_wdata_i[cwrop_pkg::NDT_W-1:0];
        default: ;
      endcase
    end
  end

  assign c64   = {{(cwrop_pkg::COEF_W-cwrop_pkg::COS_W){cos_q[cwrop_pkg::COS_W-1]}}, cos_q};
  assign s64   = {{(cwrop_pkg::COEF_W-cwrop_pkg::SIN_W){sin_q[cwrop_pkg::SIN_W-1]}}, sin_q};
  assign n64   = {{(cwrop_pkg::COEF_W-cwrop_pkg::NM_W){1'b0}}, nm_q};
  assign inv64 = {{(cwrop_pkg::COEF_W-cwrop_pkg::INV_W){1'b0}}, inv_q};
  assign ndt64 = {{(cwrop_pkg::COEF_W-cwrop_pkg::NDT_W){1'b0}}, ndt_q};
  assign sd    = s64 - ndt64;

  // Linear entries of F and the derived operands of the coefficient products
  always_ff @(posedge clk_i) begin
    f00_q   <= (cwrop_pkg::COEF_ONE <<< 2) - (c64 + (c64 <<< 1));   // 4 - 3c
    f10_q   <= (sd <<< 1) + (sd <<< 2);                             // 6s - 6 n dt
    f43_q   <= -(s64 <<< 1);
    f44_q   <= (c64 <<< 2) - cwrop_pkg::COEF_THREE;                 // 4c - 3
    n3_q    <= n64 + (n64 <<< 1);
    n6_q    <= (n64 <<< 1) + (n64 <<< 2);
    cm1_q   <= c64 - cwrop_pkg::COEF_ONE;
    m2cm1_q <= (cwrop_pkg::COEF_ONE <<< 1) - (c64 <<< 1);          // -2(c - 1)
    p2cm1_q <= (c64 <<< 1) - (cwrop_pkg::COEF_ONE <<< 1);          //  2(c - 1)
    s4n3_q  <= (s64 <<< 2) - (ndt64 + (ndt64 <<< 1));               // 4s - 3 n dt
  end

  // ---------------------------------------------------------------------------
  // Operand selection
  // ---------------------------------------------------------------------------
  always_comb begin
    case (ctrl.a_sel)
      cwrop_pkg::A_INV: a_op = inv64;
      cwrop_pkg::A_N1:  a_op = n64;
      cwrop_pkg::A_N3:  a_op = n3_q;
      cwrop_pkg::A_N6:  a_op = n6_q;
      cwrop_pkg::A_F00: a_op = f00_q;
      cwrop_pkg::A_F10: a_op = f10_q;
      cwrop_pkg::A_ONE: a_op = cwrop_pkg::COEF_ONE;
      cwrop_pkg::A_C:   a_op = c64;
      cwrop_pkg::A_F34: a_op = s64 <<< 1;
      cwrop_pkg::A_F43: a_op = f43_q;
      cwrop_pkg::A_F44: a_op = f44_q;
      cwrop_pkg::A_K03: a_op = k_q[cwrop_pkg::KI_03];
      cwrop_pkg::A_K04: a_op = k_q[cwrop_pkg::KI_04];
      cwrop_pkg::A_K13: a_op = k_q[cwrop_pkg::KI_13];
      cwrop_pkg::A_K14: a_op = k_q[cwrop_pkg::KI_14];
      cwrop_pkg::A_K30: a_op = k_q[cwrop_pkg::KI_30];
      cwrop_pkg::A_K40: a_op = k_q[cwrop_pkg::KI_40];
      cwrop_pkg::A_K52: a_op = k_q[cwrop_pkg::KI_52];
      default:          a_op = '0;
    endcase
  end

  always_comb begin
    case (ctrl.b_sel)
      cwrop_pkg::B_X0: b_state = state_q[0];
      cwrop_pkg::B_X1: b_state = state_q[1];
      cwrop_pkg::B_X2: b_state = state_q[2];
      cwrop_pkg::B_X3: b_state = state_q[3];
      cwrop_pkg::B_X4: b_state = state_q[4];
      default:         b_state = state_q[5];
    endcase
    case (ctrl.b_sel)
      cwrop_pkg::B_S:     b_op = s64;
      cwrop_pkg::B_M2CM1: b_op = m2cm1_q;
      cwrop_pkg::B_P2CM1: b_op = p2cm1_q;
      cwrop_pkg::B_S4N3:  b_op = s4n3_q;
      cwrop_pkg::B_CM1:   b_op = cm1_q;
      cwrop_pkg::B_X0, cwrop_pkg::B_X1, cwrop_pkg::B_X2,
      cwrop_pkg::B_X3, cwrop_pkg::B_X4, cwrop_pkg::B_X5:
        b_op = {{(cwrop_pkg::COEF_W-cwrop_pkg::STATE_W){b_state[cwrop_pkg::STATE_W-1]}},
                b_state};
      default:            b_op = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer and arithmetic unit
  // ---------------------------------------------------------------------------
  cwrop_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc & op_i),
    .cfg_we_i   (cfg_we_i),
    .out_free_i (out_free),
    .busy_o     (busy),
    .ctrl_o     (ctrl)
  );

  cwrop_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .a_i      (a_op),
    .b_i      (b_op),
    .coef_o   (coef_res),
    .row_o    (row_res),
    .row_ov_o (row_ov)
  );

  // ---------------------------------------------------------------------------
  // Coefficient store, new-state buffer, result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (ctrl.cend) k_q[ctrl.kdst] <= coef_res;
    if (ctrl.rend) nxt_q[ctrl.row] <= row_res;
    if (ctrl.commit) begin
      pos_x_q <= nxt_q[0];
      pos_y_q <= nxt_q[1];
      pos_z_q <= nxt_q[2];
      ov_q    <= ov_acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cwrop_pkg::N_STATE; i++) state_q[i] <= '0;
      out_valid_q <= 1'b0;
      ov_acc_q    <= 1'b0;
    end else begin
      if (in_acc && !op_i) begin
        state_q[0] <= load_x_i;
        state_q[1] <= load_y_i;
        state_q[2] <= load_z_i;
        state_q[3] <= load_vx_i;
        state_q[4] <= load_vy_i;
        state_q[5] <= load_vz_i;
      end else if (ctrl.commit) begin
        for (int i = 0; i < cwrop_pkg::N_STATE; i++) state_q[i] <= nxt_q[i];
      end

      if (ctrl.commit)                  out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      if (ctrl.commit)    ov_acc_q <= 1'b0;
      else if (ctrl.rend) ov_acc_q <= ov_acc_q | row_ov;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign pos_z_o     = pos_z_q;
  assign overflow_o  = ov_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit |-> (!out_valid_q || out_ready_i))
    else $error("result committed over a pending result");

endmodule

FILE: rtl/cwrop_seq.sv
// Microcode sequencer: step counter, phase counter, branch on coefficient state.
module cwrop_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 cfg_we_i,
  input  logic                 out_free_i,
  output logic                 busy_o,
  output cwrop_pkg::ctrl_t     ctrl_o
);

  cwrop_pkg::seq_state_e           state_q, state_d;
  logic [cwrop_pkg::STEP_W-1:0]    step_q, step_d;
  logic [cwrop_pkg::PH_W-1:0]      ph_q, ph_d;
  logic                            cvld_q, cvld_d;
  cwrop_pkg::uword_t               word;
  logic                            last_ph;
  logic                            run;

  assign word = cwrop_pkg::ucode(step_q);
  assign run  = (state_q == cwrop_pkg::SEQ_RUN);

  always_comb begin
    case (word.op)
      cwrop_pkg::UOP_MAC:  last_ph = (ph_q == cwrop_pkg::PH_MAC_LAST);
      cwrop_pkg::UOP_CEND,
      cwrop_pkg::UOP_REND: last_ph = (ph_q == cwrop_pkg::PH_END_LAST);
      default:             last_ph = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    ph_d    = ph_q;
    unique case (state_q)
      cwrop_pkg::SEQ_IDLE: begin
        if (start_i) begin
          state_d = cwrop_pkg::SEQ_RUN;
          step_d  = '0;
          ph_d    = '0;
        end
      end
      cwrop_pkg::SEQ_RUN: begin
        if (word.op == cwrop_pkg::UOP_DONE) begin
          if (out_free_i) state_d = cwrop_pkg::SEQ_IDLE;
        end else if (last_ph) begin
          ph_d = '0;
          if (word.op == cwrop_pkg::UOP_BR && cvld_q) step_d = word.tgt;
          else step_d = step_q + cwrop_pkg::STEP_W'(1);
        end else begin
          ph_d = ph_q + cwrop_pkg::PH_W'(1);
        end
      end
    endcase
  end

  always_comb begin
    cvld_d = cvld_q;
    if (cfg_we_i) cvld_d = 1'b0;
    else if (run && word.op == cwrop_pkg::UOP_CDONE) cvld_d = 1'b1;
  end

  // outputs
  always_comb begin
    busy_o        = run;
    ctrl_o.mac_en = run && (word.op == cwrop_pkg::UOP_MAC);
    ctrl_o.pp     = ph_q;
    ctrl_o.a_sel  = word.a_sel;
    ctrl_o.b_sel  = word.b_sel;
    ctrl_o.cend   = run && (word.op == cwrop_pkg::UOP_CEND) && (ph_q == cwrop_pkg::PH_END_LAST);
    ctrl_o.rend   = run && (word.op == cwrop_pkg::UOP_REND) && (ph_q == cwrop_pkg::PH_END_LAST);
    ctrl_o.kdst   = word.kdst;
    ctrl_o.row    = word.row;
    ctrl_o.neg    = word.neg;
    ctrl_o.commit = run && (word.op == cwrop_pkg::UOP_DONE) && out_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cwrop_pkg::SEQ_IDLE;
      step_q  <= '0;
      ph_q    <= '0;
      cvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ph_q    <= ph_d;
      cvld_q  <= cvld_d;
    end
  end

  a_step_in_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run |-> (step_q < cwrop_pkg::STEP_W'(cwrop_pkg::UC_LEN)))
    else $error("step counter left the program");

  a_commit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.commit |=> (state_q == cwrop_pkg::SEQ_IDLE))
    else $error("sequencer did not return to idle after commit");

endmodule

FILE: rtl/cwrop_mac.sv
// Shared 33x33 signed multiplier, product register, 128-bit accumulator,
// rounding and saturation of the accumulated sum.
module cwrop_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cwrop_pkg::ctrl_t                      ctrl_i,
  input  logic signed [cwrop_pkg::COEF_W-1:0]   a_i,
  input  logic signed [cwrop_pkg::COEF_W-1:0]   b_i,
  output logic signed [cwrop_pkg::COEF_W-1:0]   coef_o,
  output logic signed [cwrop_pkg::STATE_W-1:0]  row_o,
  output logic                                  row_ov_o
);

  logic signed [cwrop_pkg::MUL_W-1:0]  ma, mb;
  logic signed [cwrop_pkg::PROD_W-1:0] prod;
  logic signed [cwrop_pkg::PROD_W-1:0] p_q;
  logic [cwrop_pkg::PH_W-1:0]          p_pp_q;
  logic                                p_vld_q;
  logic signed [cwrop_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic signed [cwrop_pkg::ACC_W-1:0]  ext, addend;
  logic signed [cwrop_pkg::COEF_W-1:0] k_sat;
  logic                                k_fit, r_fit;

  // pp[1] picks the high chunk of a, pp[0] the high chunk of b
  always_comb begin
    if (ctrl_i.pp[1]) ma = {a_i[cwrop_pkg::COEF_W-1], a_i[cwrop_pkg::COEF_W-1:cwrop_pkg::CHUNK_W]};
    else              ma = {1'b0, a_i[cwrop_pkg::CHUNK_W-1:0]};
    if (ctrl_i.pp[0]) mb = {b_i[cwrop_pkg::COEF_W-1], b_i[cwrop_pkg::COEF_W-1:cwrop_pkg::CHUNK_W]};
    else              mb = {1'b0, b_i[cwrop_pkg::CHUNK_W-1:0]};
  end

  assign prod = ma * mb;

  always_comb begin
    ext = {{(cwrop_pkg::ACC_W-cwrop_pkg::PROD_W){p_q[cwrop_pkg::PROD_W-1]}}, p_q};
    unique case (p_pp_q)
      2'd0:       addend = ext;
      2'd1, 2'd2: addend = ext <<< cwrop_pkg::CHUNK_W;
      2'd3:       addend = ext <<< (2 * cwrop_pkg::CHUNK_W);
    endcase
  end

  // accumulator restarts at one half LSB so the final shift rounds half up
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.cend || ctrl_i.rend) acc_d = cwrop_pkg::ACC_HALF;
    else if (p_vld_q)               acc_d = acc_q + addend;
  end

  always_comb begin
    k_fit = (&acc_q[cwrop_pkg::ACC_W-1:cwrop_pkg::HI_K]) |
            (~|acc_q[cwrop_pkg::ACC_W-1:cwrop_pkg::HI_K]);
    if (k_fit)
      k_sat = {{(cwrop_pkg::COEF_W-cwrop_pkg::CLAMP_W){acc_q[cwrop_pkg::HI_K]}},
               acc_q[cwrop_pkg::HI_K:cwrop_pkg::COEF_FRAC_BITS]};
    else
      k_sat = acc_q[cwrop_pkg::ACC_W-1] ? cwrop_pkg::K_MIN : cwrop_pkg::K_MAX;
    coef_o = ctrl_i.neg ? -k_sat : k_sat;

    r_fit = (&acc_q[cwrop_pkg::ACC_W-1:cwrop_pkg::HI_R]) |
            (~|acc_q[cwrop_pkg::ACC_W-1:cwrop_pkg::HI_R]);
    if (r_fit) row_o = acc_q[cwrop_pkg::HI_R:cwrop_pkg::COEF_FRAC_BITS];
    else       row_o = acc_q[cwrop_pkg::ACC_W-1] ? cwrop_pkg::S_MIN : cwrop_pkg::S_MAX;
    row_ov_o = ~r_fit;
  end

  always_ff @(posedge clk_i) begin
    p_q    <= prod;
    p_pp_q <= ctrl_i.pp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      acc_q   <= cwrop_pkg::ACC_HALF;
    end else begin
      p_vld_q <= ctrl_i.mac_en;
      acc_q   <= acc_d;
    end
  end

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.cend || ctrl_i.rend) |-> !p_vld_q)
    else $error("accumulator read before last partial product was added");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for cw_relative_orbit_propagator_unit.
// A scoreboard follows every accepted request: loads overwrite its copy of the
// relative state, and steps run the CW update in wide integer math and queue
// the expected position fix. Config writes are decoded off the same port the
// block sees, so the coefficient copy always matches the hardware's.
module testbench;

  localparam int STATE_W        = cwrop_pkg::STATE_W;
  localparam int N_STATE        = cwrop_pkg::N_STATE;
  localparam int COEF_W         = cwrop_pkg::COEF_W;
  localparam int ACC_W          = cwrop_pkg::ACC_W;
  localparam int COEF_FRAC_BITS = cwrop_pkg::COEF_FRAC_BITS;
  localparam int CFG_IDX_W      = cwrop_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W     = cwrop_pkg::CFG_DATA_W;
  localparam int COS_W          = cwrop_pkg::COS_W;
  localparam int SIN_W          = cwrop_pkg::SIN_W;
  localparam int NM_W           = cwrop_pkg::NM_W;
  localparam int INV_W          = cwrop_pkg::INV_W;
  localparam int NDT_W          = cwrop_pkg::NDT_W;

  localparam logic signed [COEF_W-1:0]  COEF_ONE   = cwrop_pkg::COEF_ONE;
  localparam logic signed [COEF_W-1:0]  COEF_THREE = cwrop_pkg::COEF_THREE;
  localparam logic signed [ACC_W-1:0]   ACC_HALF   = cwrop_pkg::ACC_HALF;
  localparam logic signed [COEF_W-1:0]  K_MAX      = cwrop_pkg::K_MAX;
  localparam logic signed [COEF_W-1:0]  K_MIN      = cwrop_pkg::K_MIN;
  localparam logic signed [STATE_W-1:0] S_MAX      = cwrop_pkg::S_MAX;
  localparam logic signed [STATE_W-1:0] S_MIN      = cwrop_pkg::S_MIN;

  // op_i codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // A step right after a register write is the slowest case for the block.
  localparam int SETTLE_CYCLES = 160;
  localparam int HOLD_CYCLES   = 600;   // long receiver back-pressure
  localparam int BLOCK_ITEMS   = 175;   // minimum requests per random config block
  localparam int N_BLOCKS      = 6;

  // Indexes past the register list; the block must ignore writes there.
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO =
    CFG_IDX_W'(cwrop_pkg::CFG_NDT) + CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = '1;

  localparam logic signed [STATE_W-1:0] ONE_M = 48'sd65536;  // 1.0 in Q32.16
  localparam logic signed [STATE_W-1:0] P5    = 48'sh5555_5555_5555;
  localparam logic signed [STATE_W-1:0] PA    = 48'shAAAA_AAAA_AAAA;

  localparam real Q32_SCALE = 4294967296.0;
  localparam real MU_MOON   = 4.9048695e12;
  localparam real R_MOON    = 1737447.78;

  typedef logic [N_STATE-1:0][STATE_W-1:0] state_words_t;

  typedef struct packed {
    logic signed [STATE_W-1:0] x, y, z;
    logic                      ov;
  } fix_t;

  typedef enum logic [1:0] {ROW_LOAD, ROW_STEP, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    state_words_t          word;
    logic                  typed;    // fix below is the literal answer
    fix_t                  fix;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } orbit_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic                         op_i;
  logic signed [STATE_W-1:0]    load_x_i, load_y_i, load_z_i;
  logic signed [STATE_W-1:0]    load_vx_i, load_vy_i, load_vz_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic signed [STATE_W-1:0]    pos_x_o, pos_y_o, pos_z_o;
  logic                         overflow_o;
  logic                         cfg_we_i;
  logic [CFG_IDX_W-1:0]         cfg_idx_i;
  logic [CFG_DATA_W-1:0]        cfg_wdata_i;

  // Travels with the offered request: typed answer for directed rows.
  logic offer_typed;
  fix_t offer_fix;

  // Scoreboard copy of the block
  logic signed [STATE_W-1:0] orbit [N_STATE];
  logic signed [COEF_W-1:0]  r_cos, r_sin, r_nm, r_inv, r_ndt;
  fix_t                      expected_fixes [$];

  // Directed stimulus table
  orbit_row_t rows [$];

  int mismatches;
  int tx_idle_pct, rx_idle_pct;
  bit rx_hold_req;

  cw_relative_orbit_propagator_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .load_x_i    (load_x_i),
    .load_y_i    (load_y_i),
    .load_z_i    (load_z_i),
    .load_vx_i   (load_vx_i),
    .load_vy_i   (load_vy_i),
    .load_vz_i   (load_vz_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .pos_z_o     (pos_z_o),
    .overflow_o  (overflow_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Generous cap: a few times the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ------------------------------------------------------------------
  // CW math
  // ------------------------------------------------------------------

  // Product of two Q.32 values back to Q.32: round half up, clamp to 63 bits.
  function automatic logic signed [COEF_W-1:0] coef_round(
      input logic signed [COEF_W-1:0] a, input logic signed [COEF_W-1:0] b);
    logic signed [ACC_W-1:0] wa, wb, p;
    wa = ACC_W'(a);
    wb = ACC_W'(b);
    p = (wa * wb + ACC_HALF) >>> COEF_FRAC_BITS;
    if (p > ACC_W'(K_MAX)) return K_MAX;
    if (p < ACC_W'(K_MIN)) return K_MIN;
    return p[COEF_W-1:0];
  endfunction

  // One step: state <- F * state, saturating each element to 48 bits.
  task automatic advance_orbit(output fix_t fx);
    logic signed [COEF_W-1:0]  f [0:N_STATE-1][0:N_STATE-1];
    logic signed [COEF_W-1:0]  cm1;
    logic signed [ACC_W-1:0]   acc, wf, ws;
    logic signed [STATE_W-1:0] nxt [N_STATE];
    logic                      ov;
    int                        i, j;
    for (i = 0; i < N_STATE; i++) begin
      for (j = 0; j < N_STATE; j++) f[i][j] = '0;
    end
    cm1 = r_cos - COEF_ONE;
    f[0][0] = (COEF_ONE <<< 2) - 64'sd3 * r_cos;
    f[0][3] = coef_round(r_inv, r_sin);
    f[0][4] = coef_round(r_inv, -64'sd2 * cm1);
    f[1][0] = 64'sd6 * r_sin - 64'sd6 * r_ndt;
    f[1][1] = COEF_ONE;
    f[1][3] = coef_round(r_inv, 64'sd2 * cm1);
    f[1][4] = coef_round(r_inv, 64'sd4 * r_sin - 64'sd3 * r_ndt);
    f[2][2] = r_cos;
    f[2][5] = f[0][3];
    f[3][0] = coef_round(64'sd3 * r_nm, r_sin);
    f[3][3] = r_cos;
    f[3][4] = 64'sd2 * r_sin;
    f[4][0] = coef_round(64'sd6 * r_nm, cm1);
    f[4][3] = -64'sd2 * r_sin;
    f[4][4] = 64'sd4 * r_cos - COEF_THREE;
    f[5][2] = -coef_round(r_nm, r_sin);
    f[5][5] = r_cos;

    ov = 1'b0;
    for (i = 0; i < N_STATE; i++) begin
      acc = '0;
      for (j = 0; j < N_STATE; j++) begin
        wf = ACC_W'(f[i][j]);
        ws = ACC_W'(orbit[j]);
        acc = acc + wf * ws;
      end
      acc = (acc + ACC_HALF) >>> COEF_FRAC_BITS;
      if (acc > ACC_W'(S_MAX)) begin
        nxt[i] = S_MAX;
        ov = 1'b1;
      end else if (acc < ACC_W'(S_MIN)) begin
        nxt[i] = S_MIN;
        ov = 1'b1;
      end else begin
        nxt[i] = acc[STATE_W-1:0];
      end
    end
    for (i = 0; i < N_STATE; i++) orbit[i] = nxt[i];
    fx.x  = orbit[0];
    fx.y  = orbit[1];
    fx.z  = orbit[2];
    fx.ov = ov;
  endtask

  task automatic flag_mismatch(input string what, input logic [STATE_W-1:0] got,
                               input logic [STATE_W-1:0] want);
    mismatches++;
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  function automatic void append_fix(input fix_t fx);
    expected_fixes.insert(expected_fixes.size(), fx);
  endfunction

  function automatic void add_row(input orbit_row_t r);
    rows.insert(rows.size(), r);
  endfunction

  // ------------------------------------------------------------------
  // Scoreboard: everything sampled on the rising edge
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin : track_orbit
    fix_t fx;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cwrop_pkg::CFG_COS:
            r_cos = {{(COEF_W-COS_W){cfg_wdata_i[COS_W-1]}}, cfg_wdata_i[COS_W-1:0]};
          cwrop_pkg::CFG_SIN:
            r_sin = {{(COEF_W-SIN_W){cfg_wdata_i[SIN_W-1]}}, cfg_wdata_i[SIN_W-1:0]};
          cwrop_pkg::CFG_NM:  r_nm  = COEF_W'(cfg_wdata_i[NM_W-1:0]);
          cwrop_pkg::CFG_INV: r_inv = COEF_W'(cfg_wdata_i[INV_W-1:0]);
          cwrop_pkg::CFG_NDT: r_ndt = COEF_W'(cfg_wdata_i[NDT_W-1:0]);
          default: ;  // unused index, dropped
        endcase
      end

      if (in_valid_i && in_ready_o) begin
        if (op_i == OP_STEP) begin
          advance_orbit(fx);
          append_fix(offer_typed ? offer_fix : fx);
        end else begin
          orbit[0] = load_x_i;
          orbit[1] = load_y_i;
          orbit[2] = load_z_i;
          orbit[3] = load_vx_i;
          orbit[4] = load_vy_i;
          orbit[5] = load_vz_i;
        end
      end

      if (out_valid_o && out_ready_i) begin
        if (expected_fixes.size() == 0) begin
          flag_mismatch("result with nothing pending", pos_x_o, '0);
        end else begin
          fx = expected_fixes.pop_front();
          if (pos_x_o !== fx.x) flag_mismatch("pos_x", pos_x_o, fx.x);
          if (pos_y_o !== fx.y) flag_mismatch("pos_y", pos_y_o, fx.y);
          if (pos_z_o !== fx.z) flag_mismatch("pos_z", pos_z_o, fx.z);
          if (overflow_o !== fx.ov)
            flag_mismatch("overflow", STATE_W'(overflow_o), STATE_W'(fx.ov));
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Receiver: random ready, plus one long hold-off on request
  // ------------------------------------------------------------------
  initial begin : receiver
    int held;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk_i);
          held++;
        end
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  function automatic logic signed [STATE_W-1:0] state_word();
    logic signed [32:0] near;
    case ($urandom_range(9))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3, 4: return STATE_W'({$urandom, $urandom});
      default: begin
        // within about +-65 km / +-65 km/s: keeps the orbit mostly unsaturated
        near = 33'({$urandom, $urandom});
        return STATE_W'(near);
      end
    endcase
  endfunction

  function automatic state_words_t noise_words();
    state_words_t w;
    for (int i = 0; i < N_STATE; i++) w[i] = STATE_W'({$urandom, $urandom});
    return w;
  endfunction

  function automatic state_words_t fresh_state();
    state_words_t w;
    for (int i = 0; i < N_STATE; i++) w[i] = state_word();
    return w;
  endfunction

  function automatic fix_t fix_of(input logic signed [STATE_W-1:0] x, y, z,
                                  input logic ov);
    fix_t fx;
    fx.x  = x;
    fx.y  = y;
    fx.z  = z;
    fx.ov = ov;
    return fx;
  endfunction

  function automatic orbit_row_t load_row(input logic signed [STATE_W-1:0] x, y, z,
                                          input logic signed [STATE_W-1:0] vx, vy, vz);
    orbit_row_t r;
    r = '0;
    r.kind = ROW_LOAD;
    r.word = {vz, vy, vx, z, y, x};
    return r;
  endfunction

  function automatic orbit_row_t step_row(input logic typed, input fix_t fx);
    orbit_row_t r;
    r = '0;
    r.kind  = ROW_STEP;
    r.word  = noise_words();  // ignored by a step
    r.typed = typed;
    r.fix   = fx;
    return r;
  endfunction

  function automatic orbit_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    orbit_row_t r;
    r = '0;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Offer one request; returns at the edge where it is taken.
  task automatic send_request(input logic op, input state_words_t w,
                              input logic typed, input fix_t fx);
    while ($urandom_range(99) < tx_idle_pct) @(negedge clk_i) in_valid_i <= 1'b0;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    op_i        <= op;
    load_x_i    <= w[0];
    load_y_i    <= w[1];
    load_z_i    <= w[2];
    load_vx_i   <= w[3];
    load_vy_i   <= w[4];
    load_vz_i   <= w[5];
    offer_typed <= typed;
    offer_fix   <= fx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drain all pending fixes, then give a trailing load time to land.
  task automatic settle();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (expected_fixes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic poke_reg(input logic [CFG_IDX_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  // All five registers plus a junk write to an unused index.
  task automatic program_orbit(input logic [CFG_DATA_W-1:0] c, s, n, inv, ndt);
    poke_reg(cwrop_pkg::CFG_COS, c);
    poke_reg(cwrop_pkg::CFG_SIN, s);
    poke_reg(cwrop_pkg::CFG_NM, n);
    poke_reg(cwrop_pkg::CFG_INV, inv);
    poke_reg(cwrop_pkg::CFG_NDT, ndt);
    poke_reg(CFG_IDX_W'($urandom_range(SPARE_IDX_LO, SPARE_IDX_HI)),
             CFG_DATA_W'({$urandom, $urandom}));
  endtask

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin : stimulus
    orbit_row_t            r;
    logic [CFG_DATA_W-1:0] v_cos, v_sin, v_nm, v_inv, v_ndt;
    longint                q;
    real                   alt_m, dt_s, n_r, theta;
    int                    k, blk, sent, run;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    op_i        = OP_LOAD;
    load_x_i    = '0;
    load_y_i    = '0;
    load_z_i    = '0;
    load_vx_i   = '0;
    load_vy_i   = '0;
    load_vz_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = cwrop_pkg::CFG_COS;
    cfg_wdata_i = '0;
    offer_typed = 1'b0;
    offer_fix   = '0;
    mismatches  = 0;
    tx_idle_pct = 10;
    rx_idle_pct = 79;
    rx_hold_req = 1'b0;
    for (k = 0; k < N_STATE; k++) orbit[k] = '0;
    r_cos = COEF_ONE;
    r_sin = '0;
    r_nm  = '0;
    r_inv = '0;
    r_ndt = '0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed part. Reset config (cos 1, everything else 0, so zero mean
    // motion) makes F the identity: a step hands back the loaded position.
    add_row(step_row(1'b1, fix_of('0, '0, '0, 1'b0)));      // step from reset
    add_row(load_row(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
    add_row(step_row(1'b1, fix_of(S_MAX, S_MAX, S_MAX, 1'b0)));
    add_row(step_row(1'b1, fix_of(S_MAX, S_MAX, S_MAX, 1'b0)));
    add_row(load_row(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
    add_row(step_row(1'b1, fix_of(S_MIN, S_MIN, S_MIN, 1'b0)));
    add_row(load_row(48'sd1, -48'sd1, P5, PA, P5, PA));
    add_row(step_row(1'b1, fix_of(48'sd1, -48'sd1, P5, 1'b0)));
    add_row(load_row(PA, P5, -48'sd1, 48'sd1, '0, S_MAX));
    add_row(step_row(1'b1, fix_of(PA, P5, -48'sd1, 1'b0)));
    // cos = -1 alone: x' = 7x, y' = y, z' = -z, vy' = -7vy, vx' = -vx
    add_row(reg_row(cwrop_pkg::CFG_COS, CFG_DATA_W'(-COEF_ONE)));
    add_row(load_row(S_MAX, 48'sd5, S_MIN, '0, '0, '0));
    add_row(step_row(1'b1, fix_of(S_MAX, 48'sd5, S_MAX, 1'b1)));  // x and -min clip
    add_row(load_row(ONE_M, '0, 48'sd3, '0, '0, '0));
    add_row(step_row(1'b1, fix_of(ONE_M * 48'sd7, '0, -48'sd3, 1'b0)));
    add_row(load_row('0, '0, '0, '0, 48'sd1 <<< 45, '0));
    add_row(step_row(1'b1, fix_of('0, '0, '0, 1'b1)));      // only vy clips
    add_row(step_row(1'b1, fix_of('0, '0, '0, 1'b1)));
    // a real-looking orbit; from here the scoreboard does the math
    add_row(reg_row(cwrop_pkg::CFG_SIN, CFG_DATA_W'(COEF_ONE >>> 1)));
    add_row(reg_row(cwrop_pkg::CFG_NM, CFG_DATA_W'(33'd4294967)));
    add_row(reg_row(cwrop_pkg::CFG_INV, CFG_DATA_W'(COEF_ONE * 64'sd1000)));
    add_row(reg_row(cwrop_pkg::CFG_NDT, CFG_DATA_W'(36'd2248790000)));
    add_row(reg_row(SPARE_IDX_HI, '1));                      // must be dropped
    add_row(load_row(ONE_M, -ONE_M, ONE_M * 48'sd2, 48'sd100, -48'sd100, 48'sd7));
    add_row(step_row(1'b0, '0));
    add_row(step_row(1'b0, '0));
    add_row(step_row(1'b0, '0));
    add_row(load_row(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN));
    add_row(step_row(1'b0, '0));

    for (k = 0; k < rows.size(); k++) begin
      r = rows[k];
      if (r.kind == ROW_REG) begin
        settle();
        poke_reg(r.reg_idx, r.reg_val);
      end else begin
        send_request(r.kind == ROW_STEP ? OP_STEP : OP_LOAD, r.word, r.typed, r.fix);
      end
    end

    // Random part: blocks of load-then-steps runs, one config per block.
    for (blk = 0; blk < N_BLOCKS; blk++) begin
      settle();
      if (blk < 2) begin
        tx_idle_pct = 10;
        rx_idle_pct = 79;
      end else if (blk < 4) begin
        tx_idle_pct = 79;
        rx_idle_pct = 10;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      case (blk)
        1: begin  // top of every range
          v_cos = CFG_DATA_W'(COEF_ONE);
          v_sin = CFG_DATA_W'(-COEF_ONE);
          v_nm  = CFG_DATA_W'(COEF_ONE);
          v_inv = CFG_DATA_W'(64'sd1 <<< 48);
          v_ndt = CFG_DATA_W'(64'sd1 <<< 35);
        end
        2: begin  // raw bits, well past the stated ranges
          v_cos = CFG_DATA_W'({$urandom, $urandom});
          v_sin = CFG_DATA_W'({$urandom, $urandom});
          v_nm  = CFG_DATA_W'({$urandom, $urandom});
          v_inv = CFG_DATA_W'({$urandom, $urandom});
          v_ndt = CFG_DATA_W'({$urandom, $urandom});
        end
        3: begin  // bottom of the ranges, zero mean motion
          v_cos = CFG_DATA_W'(-COEF_ONE);
          v_sin = CFG_DATA_W'(COEF_ONE);
          v_nm  = '0;
          v_inv = '0;
          v_ndt = '0;
        end
        default: begin
          // low lunar orbit, 20..500 km altitude, 1..600 s step
          alt_m = 20.0e3 + 1.0e3 * $urandom_range(480);
          dt_s  = 1.0 * $urandom_range(1, 600);
          n_r   = $sqrt(MU_MOON / ((R_MOON + alt_m) ** 3));
          theta = n_r * dt_s;
          q = longint'($cos(theta) * Q32_SCALE);
          v_cos = CFG_DATA_W'(q);
          q = longint'($sin(theta) * Q32_SCALE);
          v_sin = CFG_DATA_W'(q);
          q = longint'(n_r * Q32_SCALE);
          v_nm = CFG_DATA_W'(q);
          q = longint'(Q32_SCALE / n_r);
          v_inv = CFG_DATA_W'(q);
          q = longint'(theta * Q32_SCALE);
          v_ndt = CFG_DATA_W'(q);
        end
      endcase
      program_orbit(v_cos, v_sin, v_nm, v_inv, v_ndt);

      // back-pressure while the sender never pauses: input must stall
      if (blk == 4) rx_hold_req = 1'b1;

      sent = 0;
      while (sent < BLOCK_ITEMS) begin
        // mostly a sane initial state, sometimes raw bits
        send_request(OP_LOAD, ($urandom_range(4) == 0) ? noise_words() : fresh_state(),
                     1'b0, '0);
        sent++;
        if ($urandom_range(6) == 0) continue;  // broken run: load with no step
        run = $urandom_range(1, 12);
        repeat (run) begin
          send_request(OP_STEP, noise_words(), 1'b0, '0);
          sent++;
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
